// ----- design/bekq_pkg.sv -----
package bekq_pkg;

  localparam int TimeW          = 32;
  localparam int StepsPerDetent = 4;
  localparam int CountW         = $clog2(StepsPerDetent) + 2;
  localparam int KeyW           = 3;
  localparam int LockW          = 16;

  localparam logic [LockW-1:0] LockoutReset = LockW'(80);

  typedef enum logic [KeyW-1:0] {
    KEY_NONE   = 3'd0,
    KEY_SELECT = 3'd1,
    KEY_BACK   = 3'd2,
    KEY_UP     = 3'd3,
    KEY_DOWN   = 3'd4
  } key_t;

  typedef struct packed {
    logic             select_n;
    logic             back_n;
    logic             left_n;
    logic             right_n;
    logic             phase_a;
    logic             phase_b;
    logic [TimeW-1:0] now_ms;
  } item_t;

  // Indexed by {previous A, previous B, current A, current B}.
  localparam logic signed [1:0] StepTable [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  function automatic logic signed [1:0] step_delta(input logic [1:0] prev,
                                                   input logic [1:0] cur);
    return StepTable[{prev, cur}];
  endfunction

endpackage

// ----- design/bekq_ifs.sv -----
interface bekq_item_if;
  logic                       valid;
  logic                       ready;
  logic                       select_n;
  logic                       back_n;
  logic                       left_n;
  logic                       right_n;
  logic                       phase_a;
  logic                       phase_b;
  logic [bekq_pkg::TimeW-1:0] now_ms;

  modport source (output valid, select_n, back_n, left_n, right_n, phase_a, phase_b,
                  now_ms, input ready);
  modport sink (input valid, select_n, back_n, left_n, right_n, phase_a, phase_b,
                now_ms, output ready);
endinterface

interface bekq_key_if;
  logic                      valid;
  logic                      ready;
  logic [bekq_pkg::KeyW-1:0] key_code;

  modport source (output valid, key_code, input ready);
  modport sink (input valid, key_code, output ready);
endinterface

interface bekq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bekq_pkg::LockW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- design/bekq_in_stage.sv -----
module bekq_in_stage (
  input  logic            clk,
  input  logic            rst,
  bekq_item_if.sink       item_in,
  input  logic            take,
  output logic            fire,
  output bekq_pkg::item_t item
);
  import bekq_pkg::*;

  logic held;

  assign item_in.ready = !held || take;
  assign fire          = held && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      item.select_n <= item_in.select_n;
      item.back_n   <= item_in.back_n;
      item.left_n   <= item_in.left_n;
      item.right_n  <= item_in.right_n;
      item.phase_a  <= item_in.phase_a;
      item.phase_b  <= item_in.phase_b;
      item.now_ms   <= item_in.now_ms;
    end
  end

endmodule

// ----- design/bekq_decode.sv -----
module bekq_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  bekq_pkg::item_t            item,
  input  logic [bekq_pkg::LockW-1:0] lockout_ms,
  output bekq_pkg::key_t             key
);
  import bekq_pkg::*;

  localparam logic signed [CountW-1:0] CountMax = CountW'(StepsPerDetent);
  localparam logic signed [CountW-1:0] CountMin = -CountMax;

  logic                     phases_seen, phases_seen_next;
  logic [1:0]               prev_phases, prev_phases_next;
  logic signed [CountW-1:0] step_count, step_count_next;
  logic [TimeW-1:0]         back_allowed_at, back_allowed_at_next;

  logic [1:0]               phases;
  logic [TimeW-1:0]         since;
  logic                     back_open;
  logic signed [CountW-1:0] stepped;

  assign phases    = {item.phase_a, item.phase_b};
  assign since     = item.now_ms - back_allowed_at;
  assign back_open = !since[TimeW-1];
  assign stepped   = step_count + CountW'(step_delta(prev_phases, phases));

  always_comb begin
    phases_seen_next     = phases_seen;
    prev_phases_next     = prev_phases;
    step_count_next      = step_count;
    back_allowed_at_next = back_allowed_at;
    key                  = KEY_NONE;
    if (!item.select_n) begin
      back_allowed_at_next = item.now_ms + TimeW'(lockout_ms);
      key                  = KEY_SELECT;
    end else if (back_open && !item.back_n) begin
      key = KEY_BACK;
    end else if (!item.left_n) begin
      key = KEY_UP;
    end else if (!item.right_n) begin
      key = KEY_DOWN;
    end else if (!phases_seen) begin
      // first sample only primes the previous phases
      phases_seen_next = 1'b1;
      prev_phases_next = phases;
    end else if (phases != prev_phases) begin
      prev_phases_next = phases;
      if (stepped >= CountMax) begin
        step_count_next = '0;
        key             = KEY_DOWN;
      end else if (stepped <= CountMin) begin
        step_count_next = '0;
        key             = KEY_UP;
      end else begin
        step_count_next = stepped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phases_seen     <= 1'b0;
      prev_phases     <= '0;
      step_count      <= '0;
      back_allowed_at <= '0;
    end else if (fire) begin
      phases_seen     <= phases_seen_next;
      prev_phases     <= prev_phases_next;
      step_count      <= step_count_next;
      back_allowed_at <= back_allowed_at_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (step_count > CountMin) && (step_count < CountMax))
    else $error("step count left its detent range");

  a_lockout_arm: assert property (@(posedge clk) disable iff (rst)
    fire && !item.select_n |=>
      back_allowed_at == $past(item.now_ms + TimeW'(lockout_ms)))
    else $error("select did not arm the back lockout");

  a_back_gated: assert property (@(posedge clk) disable iff (rst)
    fire && key == KEY_BACK |-> !since[TimeW-1] && item.select_n)
    else $error("back reported during lockout");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(step_count) && $stable(prev_phases) && $stable(phases_seen))
    else $error("encoder state moved without an item");

endmodule

// ----- design/bekq_out_stage.sv -----
module bekq_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  bekq_pkg::key_t key,
  output logic           take,
  bekq_key_if.source     key_out
);
  import bekq_pkg::*;

  assign take = !key_out.valid || key_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_out.valid <= 1'b0;
    end else if (fire) begin
      key_out.valid <= 1'b1;
    end else if (key_out.ready) begin
      key_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_out.key_code <= KeyW'(key);
    end
  end

endmodule

// ----- design/button_and_encoder_key_qualifier_core.sv -----
// Key qualifier for four active-low buttons and an x4 quadrature encoder. One poll
// item gives exactly one key_code item (0 none, 1 select, 2 back, 3 up, 4 down). An
// item is registered on entry, decoded against the encoder and lockout state and
// lands in the output register. A new item is taken every cycle as long as the
// output is drained; the single state update per cycle in the decode stage sets
// that rate. Input ready follows the output side's ready combinationally. The
// lockout register resets to 80 ms and is written through the cfg channel, which is
// always ready.
module button_and_encoder_key_qualifier_core (
  input  logic        clk,
  input  logic        rst,
  bekq_item_if.sink   item_in,
  bekq_key_if.source  key_out,
  bekq_cfg_if.sink    cfg
);
  import bekq_pkg::*;

  logic             lockout_ms;
  logic [LockW-1:0] lockout;
  logic             take;
  logic             fire;
  item_t            item;
  key_t             key;

  assign cfg.ready  = 1'b1;
  assign lockout_ms = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout <= LockoutReset;
    end else if (lockout_ms) begin
      lockout <= cfg.data;
    end
  end

  bekq_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .take    (take),
    .fire    (fire),
    .item    (item)
  );

  bekq_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (item),
    .lockout_ms (lockout),
    .key        (key)
  );

  bekq_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .key     (key),
    .take    (take),
    .key_out (key_out)
  );

endmodule
